### hdl/online_welford_feature_normalizer_core_defines.svh
// Assertion macros for the Welford feature normalizer core.
`ifndef ONLINE_WELFORD_FEATURE_NORMALIZER_CORE_DEFINES_SVH
`define ONLINE_WELFORD_FEATURE_NORMALIZER_CORE_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define OWFN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define OWFN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/owfn_pkg.sv
// Shared types and constants of the Welford feature normalizer.
package owfn_pkg;

    localparam int NUM_FEAT = 5;
    localparam int FEAT_W   = 32;
    localparam int NORM_W   = 16;
    localparam int CLAMP_W  = 15;
    localparam int CNT_W    = 32;
    localparam int MEAN_W   = 48;
    localparam int MAG_W    = 49;
    localparam int SSD_W    = 64;
    localparam int DVD_W    = 64;
    localparam int DVS_W    = 36;
    localparam int STEP_W   = 7;
    localparam int PROD_W   = 98;
    localparam int HALF_W   = 32;

    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 15'd12288;
    localparam logic [SSD_W-1:0]   ONE_Q32     = 64'h0000_0001_0000_0000;
    localparam logic [SSD_W-1:0]   EPS_Q32     = 64'd43;
    localparam logic [CNT_W-1:0]   COUNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_0;
        logic signed [FEAT_W-1:0] feature_1;
        logic signed [FEAT_W-1:0] feature_2;
        logic signed [FEAT_W-1:0] feature_3;
        logic signed [FEAT_W-1:0] feature_4;
    } in_item_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm_0;
        logic signed [NORM_W-1:0] norm_1;
        logic signed [NORM_W-1:0] norm_2;
        logic signed [NORM_W-1:0] norm_3;
        logic signed [NORM_W-1:0] norm_4;
    } out_item_t;

    typedef struct packed {
        logic idle;
        logic done;
    } lane_stat_t;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_MEAN_GO  = 12'b0000_0000_0010,
        ST_MEAN_WT  = 12'b0000_0000_0100,
        ST_DELTA2   = 12'b0000_0000_1000,
        ST_MUL      = 12'b0000_0001_0000,
        ST_ACC      = 12'b0000_0010_0000,
        ST_VAR_GO   = 12'b0000_0100_0000,
        ST_VAR_WT   = 12'b0000_1000_0000,
        ST_SQRT     = 12'b0001_0000_0000,
        ST_OUT_GO   = 12'b0010_0000_0000,
        ST_OUT_WT   = 12'b0100_0000_0000,
        ST_DONE     = 12'b1000_0000_0000
    } lane_state_t;

endpackage

### hdl/owfn_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module owfn_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [owfn_pkg::DVD_W-1:0]  dividend,
    input  logic [owfn_pkg::DVS_W-1:0]  divisor,
    input  logic [owfn_pkg::STEP_W-1:0] steps,
    output logic                        done,
    output logic [owfn_pkg::DVD_W-1:0]  quotient
);
    import owfn_pkg::*;

    logic [DVD_W-1:0]  dvd_reg, dvd_next, quo_reg, quo_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next, rem_reg, rem_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [DVS_W:0]    rem_sh, rem_sub;

    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sub[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/owfn_lane.sv
// One feature lane: Welford update, variance, square root and scaled output.
module owfn_lane (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic                                ack,
    input  logic signed [owfn_pkg::FEAT_W-1:0]  feature,
    input  logic [owfn_pkg::CNT_W-1:0]          count,
    input  logic [owfn_pkg::CLAMP_W-1:0]        clamp_limit,
    output owfn_pkg::lane_stat_t                stat,
    output logic signed [owfn_pkg::NORM_W-1:0]  norm
);
    import owfn_pkg::*;

    lane_state_t              state_reg, state_next;
    logic signed [MEAN_W-1:0] mean_reg, mean_next, x_reg, x_next, x_in;
    logic [SSD_W-1:0]         ssd_reg, ssd_next;
    logic signed [MAG_W-1:0]  delta_reg, delta_next, delta2_reg, delta2_next;
    logic [PROD_W-1:0]        acc_reg, acc_next, addend;
    logic [1:0]               mul_cnt_reg, mul_cnt_next;
    logic [SSD_W-1:0]         v_reg, v_next, res_reg, res_next, bit_reg, bit_next, sq_sum;
    logic signed [NORM_W-1:0] norm_reg, norm_next;

    logic [MAG_W-1:0]         delta_mag, delta2_mag, qmag;
    logic [HALF_W-1:0]        op_a, op_b;
    logic [2*HALF_W-1:0]      pp;
    logic [MAG_W:0]           sq;
    logic [SSD_W-1:0]         prod_sh;
    logic [SSD_W:0]           ssd_sum, v_sum;
    logic                     same_sign;
    logic [CLAMP_W-1:0]       clipped;

    logic                     div_start, div_done;
    logic [DVD_W-1:0]         div_dvd, div_q;
    logic [DVS_W-1:0]         div_dvs;
    logic [STEP_W-1:0]        div_steps;

    owfn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        x_in       = {feature, 16'b0};
        delta_mag  = delta_reg[MAG_W-1] ? (MAG_W'(0) - $unsigned(delta_reg))
                                        : $unsigned(delta_reg);
        delta2_mag = delta2_reg[MAG_W-1] ? (MAG_W'(0) - $unsigned(delta2_reg))
                                         : $unsigned(delta2_reg);
        same_sign  = (delta_reg > 0 && delta2_reg > 0) || (delta_reg < 0 && delta2_reg < 0);

        // Quotient of the mean update, signed back.
        sq = delta_reg[MAG_W-1] ? ((MAG_W+1)'(0) - {1'b0, div_q[MAG_W-1:0]})
                                : {1'b0, div_q[MAG_W-1:0]};

        // Partial products of |delta| * |delta2|, 32 bits at a time.
        op_a   = '0;
        op_b   = '0;
        addend = '0;
        case (mul_cnt_reg)
            2'd0: begin
                op_a   = delta_mag[HALF_W-1:0];
                op_b   = delta2_mag[HALF_W-1:0];
            end
            2'd1: begin
                op_a   = HALF_W'(delta_mag[MAG_W-1:HALF_W]);
                op_b   = delta2_mag[HALF_W-1:0];
            end
            2'd2: begin
                op_a   = delta_mag[HALF_W-1:0];
                op_b   = HALF_W'(delta2_mag[MAG_W-1:HALF_W]);
            end
            default: begin
                op_a   = HALF_W'(delta_mag[MAG_W-1:HALF_W]);
                op_b   = HALF_W'(delta2_mag[MAG_W-1:HALF_W]);
            end
        endcase
        pp = op_a * op_b;
        case (mul_cnt_reg)
            2'd0:    addend = PROD_W'(pp);
            2'd1:    addend = PROD_W'(pp) << HALF_W;
            2'd2:    addend = PROD_W'(pp) << HALF_W;
            default: addend = PROD_W'(pp) << (2 * HALF_W);
        endcase

        prod_sh = (acc_reg[PROD_W-1:PROD_W-2] != 2'b00) ? '1 : acc_reg[PROD_W-3:HALF_W];
        ssd_sum = {1'b0, ssd_reg} + {1'b0, prod_sh};
        v_sum   = {1'b0, div_q} + {1'b0, EPS_Q32};
        sq_sum  = res_reg + bit_reg;
        qmag    = div_q[MAG_W-1:0];
        clipped = (qmag > MAG_W'(clamp_limit)) ? clamp_limit : qmag[CLAMP_W-1:0];

        div_start = 1'b0;
        div_dvd   = {delta_mag, (DVD_W-MAG_W)'(0)};
        div_dvs   = DVS_W'(count);
        div_steps = STEP_W'(MAG_W);
        case (state_reg)
            ST_MEAN_GO: begin
                div_start = 1'b1;
            end
            ST_VAR_GO: begin
                div_start = 1'b1;
                div_dvd   = ssd_reg;
                div_dvs   = DVS_W'(count - CNT_W'(1));
                div_steps = STEP_W'(DVD_W);
            end
            ST_OUT_GO: begin
                div_start = 1'b1;
                div_dvd   = {delta2_mag, (DVD_W-MAG_W)'(0)};
                div_dvs   = {res_reg[HALF_W-1:0], 4'b0};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase

        state_next   = state_reg;
        mean_next    = mean_reg;
        ssd_next     = ssd_reg;
        x_next       = x_reg;
        delta_next   = delta_reg;
        delta2_next  = delta2_reg;
        acc_next     = acc_reg;
        mul_cnt_next = mul_cnt_reg;
        v_next       = v_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        norm_next    = norm_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    x_next     = x_in;
                    delta_next = {x_in[MEAN_W-1], x_in} - {mean_reg[MEAN_W-1], mean_reg};
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO: begin
                state_next = ST_MEAN_WT;
            end
            ST_MEAN_WT: begin
                if (div_done) begin
                    mean_next  = mean_reg + $signed(sq[MEAN_W-1:0]);
                    state_next = ST_DELTA2;
                end
            end
            ST_DELTA2: begin
                delta2_next  = {x_reg[MEAN_W-1], x_reg} - {mean_reg[MEAN_W-1], mean_reg};
                acc_next     = '0;
                mul_cnt_next = 2'd0;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                acc_next     = acc_reg + addend;
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd3) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (same_sign) begin
                    ssd_next = ssd_sum[SSD_W] ? '1 : ssd_sum[SSD_W-1:0];
                end
                if (count > CNT_W'(1)) begin
                    state_next = ST_VAR_GO;
                end else begin
                    v_next     = ONE_Q32 + EPS_Q32;
                    res_next   = '0;
                    bit_next   = SSD_W'(1) << (SSD_W - 2);
                    state_next = ST_SQRT;
                end
            end
            ST_VAR_GO: begin
                state_next = ST_VAR_WT;
            end
            ST_VAR_WT: begin
                if (div_done) begin
                    v_next     = v_sum[SSD_W] ? '1 : v_sum[SSD_W-1:0];
                    res_next   = '0;
                    bit_next   = SSD_W'(1) << (SSD_W - 2);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (v_reg >= sq_sum) begin
                    v_next   = v_reg - sq_sum;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    state_next = ST_OUT_GO;
                end
            end
            ST_OUT_GO: begin
                state_next = ST_OUT_WT;
            end
            ST_OUT_WT: begin
                if (div_done) begin
                    norm_next  = delta2_reg[MAG_W-1] ? (NORM_W'(0) - NORM_W'(clipped))
                                                     : NORM_W'(clipped);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mean_reg  <= '0;
            ssd_reg   <= ONE_Q32;
        end else begin
            state_reg <= state_next;
            mean_reg  <= mean_next;
            ssd_reg   <= ssd_next;
        end
        x_reg       <= x_next;
        delta_reg   <= delta_next;
        delta2_reg  <= delta2_next;
        acc_reg     <= acc_next;
        mul_cnt_reg <= mul_cnt_next;
        v_reg       <= v_next;
        res_reg     <= res_next;
        bit_reg     <= bit_next;
        norm_reg    <= norm_next;
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign norm      = norm_reg;

endmodule

### hdl/online_welford_feature_normalizer_core.sv
// Top level of the Welford online z-score feature normalizer.
//
// Takes one item of five signed Q16.16 features and returns one item of five
// signed Q4.12 z-scores. Each feature has its own lane holding its running
// mean and sum of squared deviations; the sample count is shared and
// saturates at 2^32 - 1. A lane runs three restoring divides at one bit per
// cycle (mean update; variance, skipped on the first sample; scaled output),
// a 32x32 partial-product multiply in four steps and a 32-step integer
// square root. All lanes start together on acceptance; the merging stage
// waits for every lane and for the result register to be free, then loads
// it, after which the next item may be accepted even while the result still
// waits for m_ready. clamp_limit resets to 3.0 and is written through
// cfg_valid/cfg_data, always ready; the user must write it only while the
// block is idle, which the block itself does not enforce. No clearing pass
// after reset is needed.
`include "online_welford_feature_normalizer_core_defines.svh"

module online_welford_feature_normalizer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  owfn_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output owfn_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [owfn_pkg::CLAMP_W-1:0]        cfg_data
);
    import owfn_pkg::*;

    logic [CNT_W-1:0]         sample_count_reg, sample_count_next;
    logic [CLAMP_W-1:0]       clamp_limit_reg, clamp_limit_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                out_reg, out_next;

    logic signed [FEAT_W-1:0] feat [NUM_FEAT];
    logic signed [NORM_W-1:0] norm [NUM_FEAT];
    lane_stat_t               stat [NUM_FEAT];
    logic [NUM_FEAT-1:0]      idle_vec, done_vec;
    logic                     accept, all_done, out_load;

    // Split the input item across the lanes.
    assign feat[0] = s_data.feature_0;
    assign feat[1] = s_data.feature_1;
    assign feat[2] = s_data.feature_2;
    assign feat[3] = s_data.feature_3;
    assign feat[4] = s_data.feature_4;

    for (genvar i = 0; i < NUM_FEAT; i++) begin : g_lane
        owfn_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .start       (accept),
            .ack         (out_load),
            .feature     (feat[i]),
            .count       (sample_count_reg),
            .clamp_limit (clamp_limit_reg),
            .stat        (stat[i]),
            .norm        (norm[i])
        );
        assign idle_vec[i] = stat[i].idle;
        assign done_vec[i] = stat[i].done;
    end

    // Take a new item only when every lane is free.
    assign s_ready   = &idle_vec;
    assign accept    = s_valid && s_ready;
    assign all_done  = &done_vec;
    // Merge: load the result register once all lanes finish and the slot is free.
    assign out_load  = all_done && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;

    always_comb begin
        sample_count_next = sample_count_reg;
        clamp_limit_next  = clamp_limit_reg;
        m_valid_next      = m_valid_reg;
        out_next          = out_reg;

        // Advance the shared count, hold at the top.
        if (accept && sample_count_reg != COUNT_MAX) begin
            sample_count_next = sample_count_reg + CNT_W'(1);
        end
        if (cfg_valid && cfg_ready) begin
            clamp_limit_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            out_next.norm_0 = norm[0];
            out_next.norm_1 = norm[1];
            out_next.norm_2 = norm[2];
            out_next.norm_3 = norm[3];
            out_next.norm_4 = norm[4];
            m_valid_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            clamp_limit_reg  <= CLAMP_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            sample_count_reg <= sample_count_next;
            clamp_limit_reg  <= clamp_limit_next;
            m_valid_reg      <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `OWFN_ASSERT_NEXT(a_busy_after_accept, accept, !s_ready, "lanes idle after accept")
    `OWFN_ASSERT_NEXT(a_count_step, accept && sample_count_reg != COUNT_MAX, sample_count_reg == $past(sample_count_reg) + CNT_W'(1), "count did not advance")
    `OWFN_ASSERT_NEXT(a_count_hold, sample_count_reg == COUNT_MAX, sample_count_reg == COUNT_MAX, "count left saturation")
    `OWFN_ASSERT_SAME(a_load_when_done, out_load, all_done && !s_ready, "result loaded before lanes finished")

endmodule
